### hw/rtl/fira_pkg.sv
package fira_pkg;

	localparam int unsigned ID_W = 6;
	localparam int unsigned POOL_SIZE_DEF = 64;

	typedef enum logic {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_OCCUPIED = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t            command;
		logic [ID_W-1:0] returned_id;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		status_t         status;
	} rsp_t;

	typedef enum logic [1:0] {
		FS_INIT,
		FS_IDLE,
		FS_READ
	} fsm_state_t;

	typedef struct packed {
		logic sweep_en;
		logic accept;
		logic fetch_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic out_busy;
		logic alloc_ok;
	} dp_stat_t;

endpackage

### hw/rtl/free_id_ring_allocator_top.sv
// A release, or an allocate from an empty pool, is answered in the cycle after its
// transaction. A granted allocate pays for the registered read of the identifier
// memory at the head pointer before it loads the response register, and no request
// is taken meanwhile. Releases go one per cycle unless the response stalls. After
// reset a clearing pass loads slot i with i; no transaction is accepted until it ends.
module free_id_ring_allocator_top
	import fira_pkg::*;
#(
	parameter int unsigned POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	fira_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fira_dp #(
		.POOL_SIZE (POOL_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

### hw/rtl/fira_ctrl.sv
module fira_ctrl
	import fira_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	fsm_state_t state_q;
	fsm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_INIT: begin
				if (stat.sweep_last) begin
					state_d = FS_IDLE;
				end
			end
			FS_IDLE: begin
				if (req_valid && !stat.out_busy && stat.alloc_ok) begin
					state_d = FS_READ;
				end
			end
			FS_READ: begin
				state_d = FS_IDLE;
			end
			default: begin
				state_d = FS_INIT;
			end
		endcase
	end

	always_comb begin
		req_ready      = 1'b0;
		cmd.sweep_en   = 1'b0;
		cmd.accept     = 1'b0;
		cmd.fetch_load = 1'b0;
		case (state_q)
			FS_INIT: begin
				cmd.sweep_en = 1'b1;
			end
			FS_IDLE: begin
				req_ready  = !stat.out_busy;
				cmd.accept = req_valid && !stat.out_busy;
			end
			FS_READ: begin
				cmd.fetch_load = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/fira_dp.sv
module fira_dp
	import fira_pkg::*;
#(
	parameter int unsigned POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     req,
	output rsp_t     rsp,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  ctl_cmd_t cmd,
	output dp_stat_t stat
);

	localparam int unsigned PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam logic [PW-1:0] LAST = PW'(POOL_SIZE - 1);

	logic [ID_W-1:0] mem [POOL_SIZE];
	logic [ID_W-1:0] rd_q;

	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [PW-1:0] sweep_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic [PW-1:0] head_nxt;
	logic [PW-1:0] tail_nxt;
	logic          is_alloc;
	logic          empty;
	logic          full;
	logic          occupied;
	logic          rel_ok;
	status_t       st;

	assign head_nxt = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign is_alloc = (req.command == CMD_ALLOC);
	assign empty    = (head_q == tail_q);
	assign full     = (tail_nxt == head_q);

	// A release is occupied when tail_nxt is in the circular range from head through tail.
	always_comb begin
		if (head_q <= tail_q) begin
			occupied = (tail_nxt >= head_q) && (tail_nxt <= tail_q);
		end else begin
			occupied = (tail_nxt >= head_q) || (tail_nxt <= tail_q);
		end
	end

	always_comb begin
		if (is_alloc) begin
			st = empty ? ST_EMPTY : ST_OK;
		end else if (full) begin
			st = ST_FULL;
		end else if (occupied) begin
			st = ST_OCCUPIED;
		end else begin
			st = ST_OK;
		end
	end

	assign rel_ok = !is_alloc && !full && !occupied;

	always_ff @(posedge clk) begin
		if (cmd.sweep_en) begin
			mem[sweep_q] <= ID_W'(sweep_q);
		end else if (cmd.accept && rel_ok) begin
			mem[tail_nxt] <= req.returned_id;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= LAST;
			sweep_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep_en) begin
				sweep_q <= (sweep_q == LAST) ? '0 : sweep_q + 1'b1;
			end
			if (cmd.accept && is_alloc && !empty) begin
				head_q <= head_nxt;
			end
			if (cmd.accept && rel_ok) begin
				tail_q <= tail_nxt;
			end
			if ((cmd.accept && !(is_alloc && !empty)) || cmd.fetch_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fetch_load) begin
			rsp_q.granted_id <= rd_q;
			rsp_q.status     <= ST_OK;
		end else if (cmd.accept && !(is_alloc && !empty)) begin
			rsp_q.granted_id <= '0;
			rsp_q.status     <= st;
		end
	end

	assign rsp             = rsp_q;
	assign rsp_valid       = rsp_valid_q;
	assign stat.sweep_last = (sweep_q == LAST);
	assign stat.out_busy   = rsp_valid_q && !rsp_ready;
	assign stat.alloc_ok   = is_alloc && !empty;

endmodule
